// ===== design/sxf_pkg.sv =====
// ----------------------------------------------------------------------------
// sxf_pkg
// Shared types and constants for the sync/length/XOR frame parser.
// ----------------------------------------------------------------------------
package sxf_pkg;

    localparam int MAX_FRAME_DEF   = 256;
    localparam int QUEUE_DEPTH_DEF = 4;

    // wide enough for burst size minus 7 at the largest legal frame limit
    localparam int SIZE_W = 17;

    localparam logic [7:0] SYNC0 = 8'hAA;
    localparam logic [7:0] SYNC1 = 8'h55;

    localparam logic [2:0] ST_OK   = 3'd0;
    localparam logic [2:0] ST_SIZE = 3'd1;
    localparam logic [2:0] ST_SYNC = 3'd2;
    localparam logic [2:0] ST_LEN  = 3'd3;
    localparam logic [2:0] ST_XOR  = 3'd4;

    typedef struct packed {
        logic [7:0]        data;
        logic              last;
        logic              is_sync0;
        logic              is_sync1;
        logic              is_len;
        logic              is_cmd;
        logic              is_payload;
        logic              size_ok;
        logic [7:0]        size_m9;
        logic [SIZE_W-1:0] size_m7;
    } sxf_item_t;

endpackage

// ===== design/sxf_queue.sv =====
// ----------------------------------------------------------------------------
// sxf_queue
// Small register queue between the classifier and the frame checker.
// ----------------------------------------------------------------------------
module sxf_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_wr, do_rd;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign rd_data = mem_reg[rd_ptr_reg];
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("queue count beyond depth");
`endif

endmodule

// ===== design/sxf_front.sv =====
// ----------------------------------------------------------------------------
// sxf_front
// Counts byte position in the burst and tags each item by its role.
// ----------------------------------------------------------------------------
module sxf_front
    import sxf_pkg::*;
#(
    parameter int MAX_FRAME = MAX_FRAME_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_push,
    input  logic      q_full,
    input  logic [7:0] rx_byte,
    input  logic      burst_end,
    output logic      q_push,
    output sxf_item_t q_item
);

    localparam int CW = $clog2(MAX_FRAME + 2);

    logic [CW-1:0] pos_reg, pos_next;
    logic [CW-1:0] pos_m8;

    assign q_push = in_push && !q_full;
    assign pos_m8 = pos_reg - CW'(8);

    always_comb
    begin
        q_item.data       = rx_byte;
        q_item.last       = burst_end;
        q_item.is_sync0   = (pos_reg == CW'(0));
        q_item.is_sync1   = (pos_reg == CW'(1));
        q_item.is_len     = (pos_reg >= CW'(2)) && (pos_reg <= CW'(5));
        q_item.is_cmd     = (pos_reg == CW'(7));
        q_item.is_payload = (pos_reg >= CW'(8)) && (pos_reg < CW'(MAX_FRAME));
        q_item.size_ok    = (pos_reg >= CW'(8)) && (pos_reg < CW'(MAX_FRAME));
        q_item.size_m9    = 8'(pos_m8);
        q_item.size_m7    = SIZE_W'(pos_reg) - SIZE_W'(6);
    end

    always_comb
    begin
        pos_next = pos_reg;
        if (q_push)
        begin
            if (burst_end)
            begin
                pos_next = '0;
            end
            else if (pos_reg <= CW'(MAX_FRAME))
            begin
                pos_next = pos_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
        end
        else
        begin
            pos_reg <= pos_next;
        end
    end

endmodule

// ===== design/sxf_back.sv =====
// ----------------------------------------------------------------------------
// sxf_back
// Runs size, sync, length and XOR checks, captures the command, delays
// payload bytes by one item and holds the finished result in the output register.
// ----------------------------------------------------------------------------
module sxf_back
    import sxf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       q_empty,
    input  sxf_item_t  q_item,
    output logic       q_pop,
    input  logic       pop,
    output logic       empty,
    output logic       has_data,
    output logic [7:0] payload_byte,
    output logic       frame_done,
    output logic [7:0] command,
    output logic [7:0] payload_length,
    output logic [2:0] status
);

    logic        xor_bad, len_bad, emit;
    logic        sync_reg, sync_next;
    logic [7:0]  xor_reg, xor_next;
    logic [31:0] len_reg, len_next;
    logic [7:0]  cmd_reg, cmd_next;
    logic [7:0]  held_reg, held_next;
    logic        held_valid_reg, held_valid_next;
    logic [2:0]  st;

    logic        out_valid_reg, out_valid_next;
    logic        has_data_reg;
    logic [7:0]  payload_reg;
    logic        done_reg;
    logic [7:0]  command_reg;
    logic [7:0]  plen_reg;
    logic [2:0]  status_reg;

    assign q_pop = !q_empty && (!out_valid_reg || pop);
    assign emit  = held_valid_reg || q_item.last;

    always_comb
    begin
        sync_next = sync_reg
                    && !(q_item.is_sync0 && (q_item.data != SYNC0))
                    && !(q_item.is_sync1 && (q_item.data != SYNC1));
        xor_next  = xor_reg ^ q_item.data;
        len_next  = q_item.is_len ? {len_reg[23:0], q_item.data} : len_reg;
        cmd_next  = q_item.is_cmd ? q_item.data : cmd_reg;
        xor_bad   = (xor_next != 8'd0);
        len_bad   = (len_next != 32'(q_item.size_m7));
        if (!q_item.size_ok)
        begin
            st = ST_SIZE;
        end
        else if (!sync_next)
        begin
            st = ST_SYNC;
        end
        else if (len_bad)
        begin
            st = ST_LEN;
        end
        else if (xor_bad)
        begin
            st = ST_XOR;
        end
        else
        begin
            st = ST_OK;
        end
        held_valid_next = !q_item.last && sync_next && q_item.is_payload;
        held_next       = q_item.data;
        out_valid_next  = out_valid_reg && !pop;
        if (q_pop && emit)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_reg       <= 1'b1;
            xor_reg        <= '0;
            len_reg        <= '0;
            cmd_reg        <= '0;
            held_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (q_pop)
            begin
                held_valid_reg <= held_valid_next;
                if (q_item.last)
                begin
                    sync_reg <= 1'b1;
                    xor_reg  <= '0;
                    len_reg  <= '0;
                    cmd_reg  <= '0;
                end
                else
                begin
                    sync_reg <= sync_next;
                    xor_reg  <= xor_next;
                    len_reg  <= len_next;
                    cmd_reg  <= cmd_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            held_reg <= held_next;
        end
        if (q_pop && emit)
        begin
            has_data_reg <= held_valid_reg;
            payload_reg  <= held_valid_reg ? held_reg : 8'd0;
            done_reg     <= q_item.last;
            command_reg  <= q_item.last ? cmd_next : 8'd0;
            plen_reg     <= (q_item.last && q_item.size_ok) ? q_item.size_m9 : 8'd0;
            status_reg   <= q_item.last ? st : ST_OK;
        end
    end

    assign empty          = !out_valid_reg;
    assign has_data       = has_data_reg;
    assign payload_byte   = payload_reg;
    assign frame_done     = done_reg;
    assign command        = command_reg;
    assign payload_length = plen_reg;
    assign status         = status_reg;

`ifndef SYNTHESIS
    a_no_blank: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (done_reg || has_data_reg))
        else $error("result register holds a blank result");
    a_data_only: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !done_reg) |-> (status_reg == ST_OK && command_reg == 8'd0
                                          && plen_reg == 8'd0))
        else $error("frame report fields set on a data-only result");
    a_size_len: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && done_reg && status_reg == ST_SIZE) |-> (plen_reg == 8'd0))
        else $error("payload length reported for a bad burst size");
`endif

endmodule

// ===== design/sync_length_xor_frame_parser.sv =====
// ----------------------------------------------------------------------------
// sync_length_xor_frame_parser
// Deframer for bursts of 0xAA 0x55, 32-bit length, header, command, payload
// and closing byte, checked by an XOR over the whole burst.
// ----------------------------------------------------------------------------
// Takes one byte per cycle with no gaps required while full is low; the
// sustained rate is one item per clock while pop keeps the output register
// drained, set by the per-byte update of the checker. An accepted byte
// passes through the queue behind the classifier, then the output register,
// before its result is on the result ports and can be popped. Payload bytes
// come out one item behind the byte that carried them, and the burst report
// (command, payload length, status) rides on the result of the last byte.
// Bursts shorter than 9 or longer than MAX_FRAME bytes report bad size.
module sync_length_xor_frame_parser
    import sxf_pkg::*;
#(
    parameter int MAX_FRAME   = MAX_FRAME_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] rx_byte,
    input  logic       burst_end,
    output logic       empty,
    input  logic       pop,
    output logic       has_data,
    output logic [7:0] payload_byte,
    output logic       frame_done,
    output logic [7:0] command,
    output logic [7:0] payload_length,
    output logic [2:0] status
);

    localparam int IW = $bits(sxf_item_t);

    logic      q_push, q_pop, q_full, q_empty;
    sxf_item_t wr_item, rd_item;
    logic [IW-1:0] rd_bits;

    assign full    = q_full;
    assign rd_item = sxf_item_t'(rd_bits);

    sxf_front #(
        .MAX_FRAME (MAX_FRAME)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_push   (push),
        .q_full    (q_full),
        .rx_byte   (rx_byte),
        .burst_end (burst_end),
        .q_push    (q_push),
        .q_item    (wr_item)
    );

    sxf_queue #(
        .WIDTH (IW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_push),
        .wr_data (wr_item),
        .full    (q_full),
        .rd_en   (q_pop),
        .rd_data (rd_bits),
        .empty   (q_empty)
    );

    sxf_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_empty        (q_empty),
        .q_item         (rd_item),
        .q_pop          (q_pop),
        .pop            (pop),
        .empty          (empty),
        .has_data       (has_data),
        .payload_byte   (payload_byte),
        .frame_done     (frame_done),
        .command        (command),
        .payload_length (payload_length),
        .status         (status)
    );

endmodule
